/* rtl/gtc_pkg.sv */
package gtc_pkg;

   // Width of the prescaler field in the control register.
   localparam int PRESCALE_WIDTH = 8;

   // Operation codes carried by a request transaction.
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // Register word indices.
   localparam logic [2:0] REG_CNT_LO  = 3'd0;
   localparam logic [2:0] REG_CNT_HI  = 3'd1;
   localparam logic [2:0] REG_CTRL    = 3'd2;
   localparam logic [2:0] REG_STATUS  = 3'd3;
   localparam logic [2:0] REG_CMP_LO  = 3'd4;
   localparam logic [2:0] REG_CMP_HI  = 3'd5;
   localparam logic [2:0] REG_AUTOINC = 3'd6;

   // One request transaction as held in the input register.
   typedef struct packed {
      logic [1:0]  opcode;
      logic [2:0]  reg_index;
      logic [31:0] write_data;
   } gtc_req_type;

endpackage

/* rtl/gtc_in_reg.sv */
module gtc_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  gtc_pkg::gtc_req_type req_in,
   input  logic               advance,
   output logic               held_valid,
   output gtc_pkg::gtc_req_type held_req
);

   logic                 valid_ff;
   logic                 valid_in;
   gtc_pkg::gtc_req_type req_ff;

   // The register takes a new transaction when it is empty or drains this cycle.
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_ff <= req_in;
      end
   end

   assign held_valid = valid_ff;
   assign held_req   = req_ff;

endmodule

/* rtl/gtc_exec.sv */
module gtc_exec (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  gtc_pkg::gtc_req_type req,
   output logic [31:0]          read_data,
   output logic                 irq_next
);

   localparam int PW = gtc_pkg::PRESCALE_WIDTH;

   // Control bit positions.
   localparam int CTRL_TIMER_EN   = 0;
   localparam int CTRL_COMP_EN    = 1;
   localparam int CTRL_IRQ_EN     = 2;
   localparam int CTRL_AUTOINC_EN = 3;

   logic [63:0]   count_ff, count_in;
   logic [63:0]   compare_ff, compare_in;
   logic [31:0]   incr_ff, incr_in;
   logic [3:0]    ctrl_ff, ctrl_in;
   logic [PW-1:0] pset_ff, pset_in;
   logic [PW-1:0] pcount_ff, pcount_in;
   logic          event_ff, event_in;

   logic [63:0]   count_inc;
   logic [63:0]   compare_adv;

   // Both adders work in parallel; only the equality compare follows them.
   assign count_inc   = count_ff + 64'd1;
   assign compare_adv = compare_ff + {32'd0, incr_ff};

   always_comb begin
      count_in   = count_ff;
      compare_in = compare_ff;
      incr_in    = incr_ff;
      ctrl_in    = ctrl_ff;
      pset_in    = pset_ff;
      pcount_in  = pcount_ff;
      event_in   = event_ff;
      read_data  = 32'd0;

      unique case (req.opcode)
         gtc_pkg::OP_READ: begin
            unique case (req.reg_index)
               gtc_pkg::REG_CNT_LO:  read_data = count_ff[31:0];
               gtc_pkg::REG_CNT_HI:  read_data = count_ff[63:32];
               gtc_pkg::REG_CTRL:    read_data = 32'({pset_ff, 4'd0, ctrl_ff});
               gtc_pkg::REG_STATUS:  read_data = {31'd0, event_ff};
               gtc_pkg::REG_CMP_LO:  read_data = compare_ff[31:0];
               gtc_pkg::REG_CMP_HI:  read_data = compare_ff[63:32];
               gtc_pkg::REG_AUTOINC: read_data = incr_ff;
               default:              read_data = 32'd0;
            endcase
         end
         gtc_pkg::OP_WRITE: begin
            unique case (req.reg_index)
               gtc_pkg::REG_CNT_LO: begin
                  if (!ctrl_ff[CTRL_TIMER_EN]) begin
                     count_in[31:0] = req.write_data;
                  end
               end
               gtc_pkg::REG_CNT_HI: begin
                  if (!ctrl_ff[CTRL_TIMER_EN]) begin
                     count_in[63:32] = req.write_data;
                  end
               end
               gtc_pkg::REG_CTRL: begin
                  ctrl_in = req.write_data[3:0];
                  pset_in = req.write_data[8 +: PW];
               end
               gtc_pkg::REG_STATUS: begin
                  if (req.write_data[0]) begin
                     event_in = 1'b0;
                  end
               end
               gtc_pkg::REG_CMP_LO:  compare_in[31:0]  = req.write_data;
               gtc_pkg::REG_CMP_HI:  compare_in[63:32] = req.write_data;
               gtc_pkg::REG_AUTOINC: incr_in = req.write_data;
               default: ;
            endcase
         end
         gtc_pkg::OP_TICK: begin
            // A count above the setting also rolls over and increments.
            if (ctrl_ff[CTRL_TIMER_EN]) begin
               if (pcount_ff >= pset_ff) begin
                  pcount_in = '0;
                  count_in  = count_inc;
                  if (ctrl_ff[CTRL_COMP_EN] && (count_inc == compare_ff)) begin
                     event_in = 1'b1;
                     if (ctrl_ff[CTRL_AUTOINC_EN]) begin
                        compare_in = compare_adv;
                     end
                  end
               end else begin
                  pcount_in = pcount_ff + {{(PW-1){1'b0}}, 1'b1};
               end
            end
         end
         default: ;
      endcase
   end

   // The interrupt reflects the state after this transaction.
   assign irq_next = event_in && ctrl_in[CTRL_IRQ_EN];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         compare_ff <= '0;
         incr_ff    <= '0;
         ctrl_ff    <= '0;
         pset_ff    <= '0;
         pcount_ff  <= '0;
         event_ff   <= 1'b0;
      end else if (advance) begin
         count_ff   <= count_in;
         compare_ff <= compare_in;
         incr_ff    <= incr_in;
         ctrl_ff    <= ctrl_in;
         pset_ff    <= pset_in;
         pcount_ff  <= pcount_in;
         event_ff   <= event_in;
      end
   end

endmodule

/* rtl/global_timer_compare_autoinc_core.sv */
// 64-bit timer with compare match and comparator auto-increment, driven by a
// stream of transactions: register read, register write, one clock tick or a no-op.
// Every request transaction gives exactly one response carrying the read data
// (zero for anything but a read) and the interrupt level after that request.
// The block accepts one transaction every cycle while the response side takes
// its responses. A request waits in the input register, executes when the result
// register is free or drains, and its response then becomes valid in the result
// register. The state update between the two registers is a single pass.
// Backpressure on the response side stalls the input after one held request.
module global_timer_compare_autoinc_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [2:0]  req_reg_index,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic        rsp_irq_line
);

   gtc_pkg::gtc_req_type req_bus;
   gtc_pkg::gtc_req_type held_req;
   logic                 held_valid;
   logic                 advance;
   logic [31:0]          exec_read_data;
   logic                 exec_irq;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          read_data_ff;
   logic                 irq_ff;

   assign req_bus.opcode     = req_opcode;
   assign req_bus.reg_index  = req_reg_index;
   assign req_bus.write_data = req_write_data;

   // A held transaction executes when the result register is free or drains.
   assign advance = held_valid && (!rsp_valid_ff || rsp_ready);

   gtc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_in     (req_bus),
      .advance    (advance),
      .held_valid (held_valid),
      .held_req   (held_req)
   );

   gtc_exec u_exec (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req       (held_req),
      .read_data (exec_read_data),
      .irq_next  (exec_irq)
   );

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         read_data_ff <= exec_read_data;
         irq_ff       <= exec_irq;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = read_data_ff;
   assign rsp_irq_line  = irq_ff;

`ifndef SYNTHESIS
   // Anything but a read returns zero data.
   a_nonread_zero: assert property (@(posedge clock) disable iff (reset)
      advance && (held_req.opcode != gtc_pkg::OP_READ) |=> rsp_read_data == 32'd0)
      else $error("non-read transaction returned nonzero data");

   // A held request that cannot execute stays in the input register.
   a_hold_request: assert property (@(posedge clock) disable iff (reset)
      held_valid && !advance |=> held_valid && $stable(held_req))
      else $error("held request lost or changed while stalled");

   // Executing a transaction always leaves a response waiting.
   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("executed transaction produced no response");
`endif

endmodule

/* bench/tb_global_timer_compare_autoinc_core.sv */
`timescale 1ns / 100ps

module tb_global_timer_compare_autoinc_core;

   // Codes and widths shared with the design.
   localparam int         PRESCALE_WIDTH = gtc_pkg::PRESCALE_WIDTH;
   localparam logic [1:0] OP_READ        = gtc_pkg::OP_READ;
   localparam logic [1:0] OP_WRITE       = gtc_pkg::OP_WRITE;
   localparam logic [1:0] OP_TICK        = gtc_pkg::OP_TICK;

   localparam logic [2:0] REG_CNT_LO  = gtc_pkg::REG_CNT_LO;
   localparam logic [2:0] REG_CNT_HI  = gtc_pkg::REG_CNT_HI;
   localparam logic [2:0] REG_CTRL    = gtc_pkg::REG_CTRL;
   localparam logic [2:0] REG_STATUS  = gtc_pkg::REG_STATUS;
   localparam logic [2:0] REG_CMP_LO  = gtc_pkg::REG_CMP_LO;
   localparam logic [2:0] REG_CMP_HI  = gtc_pkg::REG_CMP_HI;
   localparam logic [2:0] REG_AUTOINC = gtc_pkg::REG_AUTOINC;

   // Codes that the package does not name.
   localparam logic [1:0] OP_NONE    = 2'd3;
   localparam logic [2:0] REG_UNUSED = 3'd7;

   localparam logic [3:0] EN_TIMER   = 4'b0001;
   localparam logic [3:0] EN_COMPARE = 4'b0010;
   localparam logic [3:0] EN_IRQ     = 4'b0100;
   localparam logic [3:0] EN_AUTOINC = 4'b1000;

   localparam logic [31:0] STATUS_CLEAR = 32'h0000_0001;
   localparam int RANDOM_ITEMS = 700;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_line;
   } timer_reply_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_opcode;
   logic [2:0]  req_reg_index;
   logic [31:0] req_write_data;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_read_data;
   logic        rsp_irq_line;

   // Shadow copy of the timer state, advanced once per accepted transaction.
   logic [63:0]               count_q      = '0;
   logic [63:0]               compare_q    = '0;
   logic [31:0]               autoinc_q    = '0;
   logic [3:0]                ctrl_q       = '0;
   logic [PRESCALE_WIDTH-1:0] prescale_q   = '0;
   logic [PRESCALE_WIDTH-1:0] prescale_cnt = '0;
   logic                      match_flag   = 1'b0;

   timer_reply_type timer_replies_due[$];
   int  error_count = 0;
   int  items_sent = 0;
   int  send_gap_max = 13;
   int  ready_stall_max = 13;
   bit  reset_done = 1'b0;

   global_timer_compare_autoinc_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_reg_index  (req_reg_index),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .rsp_irq_line   (rsp_irq_line)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [31:0] ctrl_word(input logic [3:0] enables,
                                             input logic [PRESCALE_WIDTH-1:0] div);
      ctrl_word = (32'(div) << 8) | 32'(enables);
   endfunction

   // Apply one transaction to the shadow state and queue the reply it must give.
   task automatic predict_timer_reply(input logic [1:0] op, input logic [2:0] idx,
                                      input logic [31:0] data);
      timer_reply_type reply;
      reply.read_data = '0;
      case (op)
         OP_READ: begin
            case (idx)
               REG_CNT_LO:  reply.read_data = count_q[31:0];
               REG_CNT_HI:  reply.read_data = count_q[63:32];
               REG_CTRL:    reply.read_data = ctrl_word(ctrl_q, prescale_q);
               REG_STATUS:  reply.read_data = 32'(match_flag);
               REG_CMP_LO:  reply.read_data = compare_q[31:0];
               REG_CMP_HI:  reply.read_data = compare_q[63:32];
               REG_AUTOINC: reply.read_data = autoinc_q;
               default:     reply.read_data = '0;
            endcase
         end
         OP_WRITE: begin
            case (idx)
               REG_CNT_LO: begin
                  if ((ctrl_q & EN_TIMER) == 0) count_q[31:0] = data;
               end
               REG_CNT_HI: begin
                  if ((ctrl_q & EN_TIMER) == 0) count_q[63:32] = data;
               end
               REG_CTRL: begin
                  ctrl_q = data[3:0];
                  prescale_q = data[8 +: PRESCALE_WIDTH];
               end
               REG_STATUS: begin
                  if ((data & STATUS_CLEAR) != 0) match_flag = 1'b0;
               end
               REG_CMP_LO:  compare_q[31:0] = data;
               REG_CMP_HI:  compare_q[63:32] = data;
               REG_AUTOINC: autoinc_q = data;
               default: ;
            endcase
         end
         OP_TICK: begin
            // The counter steps once every prescaler+1 enabled ticks.
            if ((ctrl_q & EN_TIMER) != 0) begin
               if (prescale_cnt >= prescale_q) begin
                  prescale_cnt = '0;
                  count_q = count_q + 64'd1;
                  if ((ctrl_q & EN_COMPARE) != 0 && count_q == compare_q) begin
                     match_flag = 1'b1;
                     if ((ctrl_q & EN_AUTOINC) != 0) compare_q = compare_q + 64'(autoinc_q);
                  end
               end else begin
                  prescale_cnt = prescale_cnt + 1'b1;
               end
            end
         end
         default: ;
      endcase
      reply.irq_line = match_flag && ((ctrl_q & EN_IRQ) != 0);
      timer_replies_due.push_back(reply);
   endtask

   // Present one request transaction after a random gap and hold it until accepted.
   task automatic send_item(input logic [1:0] op, input logic [2:0] idx,
                            input logic [31:0] data);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_reg_index  <= idx;
      req_write_data <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_timer_reply(op, idx, data);
      items_sent++;
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      send_item(OP_WRITE, idx, data);
   endtask

   task automatic read_reg(input logic [2:0] idx);
      send_item(OP_READ, idx, '0);
   endtask

   task automatic tick();
      send_item(OP_TICK, 3'($urandom), $urandom);
   endtask

   // Registers come out of reset cleared; the unused index reads zero.
   task automatic test_reset_values();
      read_reg(REG_CNT_LO);
      read_reg(REG_CTRL);
      read_reg(REG_AUTOINC);
      read_reg(REG_UNUSED);
   endtask

   // Control keeps only its defined fields, counter writes are dropped while
   // running, and the unused opcode does nothing.
   task automatic test_control_fields();
      write_reg(REG_CTRL, 32'hFFFF_FFFF);
      read_reg(REG_CTRL);
      write_reg(REG_CNT_LO, 32'hFFFF_FFFF);
      send_item(OP_NONE, REG_UNUSED, 32'hFFFF_FFFF);
   endtask

   // The counter wraps from all ones onto a zero comparator, the flag rises,
   // the comparator advances, and only a status write with bit 0 clears it.
   task automatic test_wrap_and_autoinc();
      write_reg(REG_CTRL, '0);
      write_reg(REG_CNT_LO, 32'hFFFF_FFFF);
      write_reg(REG_CNT_HI, 32'hFFFF_FFFF);
      write_reg(REG_CMP_LO, '0);
      write_reg(REG_CMP_HI, '0);
      write_reg(REG_AUTOINC, 32'hFFFF_FFFF);
      write_reg(REG_CTRL, ctrl_word(EN_TIMER | EN_COMPARE | EN_IRQ | EN_AUTOINC, '0));
      tick();
      read_reg(REG_CMP_LO);
      write_reg(REG_STATUS, 32'hFFFF_FFFE);
      write_reg(REG_STATUS, STATUS_CLEAR);
   endtask

   // Lowering the prescaler below the running count makes the next tick count,
   // and ticks do nothing once the timer is disabled.
   task automatic test_prescale_lowered();
      write_reg(REG_CTRL, ctrl_word(EN_TIMER, 8'd3));
      repeat (3) tick();
      write_reg(REG_CTRL, ctrl_word(EN_TIMER, 8'd1));
      tick();
      write_reg(REG_CTRL, '0);
      tick();
      read_reg(REG_CNT_LO);
   endtask

   // One session: load a counter close to the comparator, start the timer,
   // then mostly tick with reads, flag clears and some noise mixed in.
   task automatic run_timer_session(input int steps);
      logic [63:0]               cmp_start;
      logic [63:0]               cnt_start;
      logic [3:0]                enables;
      logic [PRESCALE_WIDTH-1:0] div;
      int                        pick;
      cmp_start = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) cmp_start[31:0] = 32'hFFFF_FFFF - $urandom_range(0, 8);
      cnt_start = cmp_start - 64'($urandom_range(0, 12));
      if ($urandom_range(0, 7) == 0) cnt_start = {$urandom, $urandom};
      write_reg(REG_CTRL, $urandom & ~32'(EN_TIMER));
      write_reg(REG_CNT_LO, cnt_start[31:0]);
      write_reg(REG_CNT_HI, cnt_start[63:32]);
      write_reg(REG_CMP_LO, cmp_start[31:0]);
      write_reg(REG_CMP_HI, cmp_start[63:32]);
      case ($urandom_range(0, 3))
         0:       write_reg(REG_AUTOINC, '0);
         1:       write_reg(REG_AUTOINC, $urandom);
         default: write_reg(REG_AUTOINC, $urandom_range(1, 16));
      endcase
      enables = 4'($urandom) | EN_TIMER;
      if ($urandom_range(0, 4) != 0) enables = enables | EN_COMPARE;
      div = ($urandom_range(0, 9) == 0) ? PRESCALE_WIDTH'($urandom)
                                        : PRESCALE_WIDTH'($urandom_range(0, 3));
      write_reg(REG_CTRL, ctrl_word(enables, div) | ($urandom & 32'hFFFF_00F0));
      for (int i = 0; i < steps; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) tick();
         else if (pick < 70) read_reg(3'($urandom));
         else if (pick < 78) write_reg(REG_STATUS, $urandom);
         else if (pick < 83) write_reg(REG_CTRL,
                                       ctrl_word(enables, PRESCALE_WIDTH'($urandom_range(0, 3))));
         else if (pick < 88) write_reg(3'($urandom), $urandom);
         else if (pick < 93) send_item(OP_NONE, 3'($urandom), $urandom);
         else send_item(2'($urandom), 3'($urandom), $urandom);
      end
   endtask

   // Random sessions rotate through the idling patterns of both sides.
   task automatic test_random_sessions();
      int target;
      int session;
      target = items_sent + RANDOM_ITEMS;
      session = 0;
      while (items_sent < target) begin
         case (session % 4)
            0: begin send_gap_max = 13; ready_stall_max = 13; end
            1: begin send_gap_max = 0;  ready_stall_max = 0;  end
            2: begin send_gap_max = 0;  ready_stall_max = 13; end
            default: begin send_gap_max = 13; ready_stall_max = 0; end
         endcase
         run_timer_session($urandom_range(15, 40));
         session++;
      end
   endtask

   // Accept each response transaction after a random stall and check it.
   initial begin
      timer_reply_type due;
      int              stall;
      rsp_ready <= 1'b0;
      wait (reset_done);
      forever begin
         stall = $urandom_range(0, ready_stall_max);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         if (timer_replies_due.size() == 0) begin
            $error("response transaction with no request outstanding");
            error_count++;
         end else begin
            due = timer_replies_due.pop_front();
            if (rsp_read_data !== due.read_data) begin
               $error("read_data: expected %h, actual %h", due.read_data, rsp_read_data);
               error_count++;
            end
            if (rsp_irq_line !== due.irq_line) begin
               $error("irq_line: expected %b, actual %b", due.irq_line, rsp_irq_line);
               error_count++;
            end
         end
      end
   end

   // Main sequence: reset, directed tests, random sessions, then drain.
   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_opcode     <= OP_READ;
      req_reg_index  <= REG_CNT_LO;
      req_write_data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      reset_done = 1'b1;

      test_reset_values();
      test_control_fields();
      test_wrap_and_autoinc();
      test_prescale_lowered();
      test_random_sessions();

      req_valid <= 1'b0;
      while (timer_replies_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("global_timer_compare_autoinc_core verification clean");
      end else begin
         $display("global_timer_compare_autoinc_core verification failed");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #1_000_000;
      $display("global_timer_compare_autoinc_core verification failed");
      $finish;
   end

endmodule
